### hw/rtl/rast_pkg.sv
package rast_pkg;

    localparam int DEF_MAX_ELEMENTS = 1024;
    localparam int CMD_W = 2;
    localparam int IDX_W = 10;
    localparam int CNT_W = 11;
    localparam int VAL_W = 32;
    localparam int SUM_W = 64;
    localparam int CNT_RESET = 1024;

    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic rd_node;
        logic calc;
        logic wr_node;
        logic chl_rd;
        logic chl_wr;
        logic chr_rd;
        logic chr_wr;
        logic descend;
        logic ret_step;
        logic emit;
    } ctrl_t;

    typedef struct packed {
        logic is_query;
        logic is_add;
        logic is_clear;
        logic range_ok;
        logic outside;
        logic full;
        logic leaf;
        logic q_nonzero;
        logic stack_empty;
        logic top_phase;
        logic clear_last;
    } stat_t;

endpackage

### hw/rtl/rast_ctrl.sv
module rast_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  rast_pkg::stat_t stat,
    output rast_pkg::ctrl_t ctrl,
    output logic            busy
);
    import rast_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_START  = 4'd2;
    localparam logic [3:0] S_VRD    = 4'd3;
    localparam logic [3:0] S_VMUL   = 4'd4;
    localparam logic [3:0] S_VWR    = 4'd5;
    localparam logic [3:0] S_CLRD   = 4'd6;
    localparam logic [3:0] S_CLWR   = 4'd7;
    localparam logic [3:0] S_CRRD   = 4'd8;
    localparam logic [3:0] S_CRWR   = 4'd9;
    localparam logic [3:0] S_DEC    = 4'd10;
    localparam logic [3:0] S_RET    = 4'd11;
    localparam logic [3:0] S_RESULT = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        ctrl = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                ctrl.clr_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (stat.is_clear)
                begin
                    state_next = S_CLEAR;
                end
                else if (stat.is_query && !stat.range_ok)
                begin
                    state_next = S_RESULT;
                end
                else if ((stat.is_query || stat.is_add) && stat.range_ok)
                begin
                    state_next = S_VRD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_VRD:
            begin
                ctrl.rd_node = 1'b1;
                state_next = S_VMUL;
            end
            S_VMUL:
            begin
                ctrl.calc = 1'b1;
                state_next = S_VWR;
            end
            S_VWR:
            begin
                ctrl.wr_node = 1'b1;
                state_next = (!stat.leaf && stat.q_nonzero) ? S_CLRD : S_DEC;
            end
            S_CLRD:
            begin
                ctrl.chl_rd = 1'b1;
                state_next = S_CLWR;
            end
            S_CLWR:
            begin
                ctrl.chl_wr = 1'b1;
                state_next = S_CRRD;
            end
            S_CRRD:
            begin
                ctrl.chr_rd = 1'b1;
                state_next = S_CRWR;
            end
            S_CRWR:
            begin
                ctrl.chr_wr = 1'b1;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (stat.outside || stat.full)
                begin
                    state_next = S_RET;
                end
                else
                begin
                    ctrl.descend = 1'b1;
                    state_next = S_VRD;
                end
            end
            S_RET:
            begin
                if (stat.stack_empty)
                begin
                    state_next = stat.is_query ? S_RESULT : S_IDLE;
                end
                else
                begin
                    ctrl.ret_step = 1'b1;
                    if (!stat.top_phase)
                    begin
                        state_next = S_VRD;
                    end
                end
            end
            S_RESULT:
            begin
                ctrl.emit = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/rast_datapath.sv
module rast_datapath #(
    parameter int MAX_ELEMENTS = rast_pkg::DEF_MAX_ELEMENTS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rast_pkg::ctrl_t               ctrl,
    output rast_pkg::stat_t               stat,
    input  logic [rast_pkg::CMD_W-1:0]    command,
    input  logic [rast_pkg::IDX_W-1:0]    first_index,
    input  logic [rast_pkg::IDX_W-1:0]    last_index,
    input  logic signed [rast_pkg::VAL_W-1:0] add_value,
    input  logic                          cfg_we,
    input  logic [rast_pkg::CNT_W-1:0]    cfg_wdata,
    output logic                          done,
    output logic signed [rast_pkg::SUM_W-1:0] range_sum
);
    import rast_pkg::*;

    localparam int NODES = 4 * MAX_ELEMENTS;
    localparam int NW    = $clog2(NODES);
    localparam int EW    = $clog2(MAX_ELEMENTS);
    localparam int CW    = $clog2(MAX_ELEMENTS + 1);
    localparam int DEPTH = $clog2(MAX_ELEMENTS) + 1;
    localparam int IW    = $clog2(DEPTH);
    localparam int SPW   = $clog2(DEPTH + 1);

    logic [SUM_W-1:0] sum_mem [NODES];
    logic [SUM_W-1:0] pend_mem [NODES];

    logic [CNT_W-1:0] count_reg;
    logic [CMD_W-1:0] cmd_reg;
    logic [IDX_W-1:0] a_reg;
    logic [IDX_W-1:0] b_reg;
    logic [SUM_W-1:0] v_reg;
    logic [CW-1:0]    n_reg;
    logic [NW-1:0]    node_reg;
    logic [EW-1:0]    lo_reg;
    logic [EW-1:0]    hi_reg;
    logic [SUM_W-1:0] ret_reg;
    logic [SUM_W-1:0] q_reg;
    logic [SUM_W-1:0] prod_reg;
    logic             outside_reg;
    logic             full_reg;
    logic [SUM_W-1:0] sum_q;
    logic [SUM_W-1:0] pend_q;
    logic [SPW-1:0]   sp_reg;
    logic [NW-1:0]    clr_cnt_reg;
    logic             done_reg;
    logic [SUM_W-1:0] range_sum_reg;

    logic [NW-1:0]    stk_node [DEPTH];
    logic [EW-1:0]    stk_lo [DEPTH];
    logic [EW-1:0]    stk_hi [DEPTH];
    logic             stk_phase [DEPTH];
    logic [SUM_W-1:0] stk_acc [DEPTH];

    logic [CW-1:0]    n_used;
    logic [IW-1:0]    push_idx;
    logic [IW-1:0]    top_idx;
    logic [SPW-1:0]   sp_m1;
    logic [EW:0]      mid_sum;
    logic [EW-1:0]    mid;
    logic [EW:0]      top_mid_sum;
    logic [EW-1:0]    top_mid;
    logic [CW-1:0]    len;
    logic             outside_c;
    logic             full_c;
    logic [SUM_W-1:0] q_c;
    logic [SUM_W-1:0] newsum;
    logic [SUM_W-1:0] total;
    logic [NW-1:0]    left_node;
    logic [NW-1:0]    right_node;
    logic [NW-1:0]    top_right;
    logic             rd_en;
    logic [NW-1:0]    rd_addr;
    logic             sum_we;
    logic [NW-1:0]    sum_wa;
    logic [SUM_W-1:0] sum_wd;
    logic             pend_we;
    logic [NW-1:0]    pend_wa;
    logic [SUM_W-1:0] pend_wd;

    // element count 0 acts as 1, larger than capacity acts as capacity
    always_comb
    begin
        if (count_reg == '0)
        begin
            n_used = CW'(1);
        end
        else if (32'(count_reg) > 32'(MAX_ELEMENTS))
        begin
            n_used = CW'(MAX_ELEMENTS);
        end
        else
        begin
            n_used = CW'(count_reg);
        end
    end

    assign sp_m1    = sp_reg - SPW'(1);
    assign push_idx = sp_reg[IW-1:0];
    assign top_idx  = sp_m1[IW-1:0];

    assign mid_sum     = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid         = mid_sum[EW:1];
    assign top_mid_sum = {1'b0, stk_lo[top_idx]} + {1'b0, stk_hi[top_idx]};
    assign top_mid     = top_mid_sum[EW:1];
    assign len         = CW'(hi_reg) - CW'(lo_reg) + CW'(1);

    assign outside_c = (32'(a_reg) > 32'(hi_reg)) || (32'(b_reg) < 32'(lo_reg));
    assign full_c    = (32'(a_reg) <= 32'(lo_reg)) && (32'(b_reg) >= 32'(hi_reg));
    assign q_c       = pend_q + (((cmd_reg == CMD_ADD) && full_c) ? v_reg : '0);
    assign newsum    = sum_q + prod_reg;
    assign total     = stk_acc[top_idx] + ret_reg;

    assign left_node  = (node_reg << 1) + NW'(1);
    assign right_node = (node_reg << 1) + NW'(2);
    assign top_right  = (stk_node[top_idx] << 1) + NW'(2);

    assign stat.is_query    = (cmd_reg == CMD_QUERY);
    assign stat.is_add      = (cmd_reg == CMD_ADD);
    assign stat.is_clear    = (cmd_reg == CMD_CLEAR);
    assign stat.range_ok    = (a_reg <= b_reg) && (32'(b_reg) < 32'(n_reg));
    assign stat.outside     = outside_reg;
    assign stat.full        = full_reg;
    assign stat.leaf        = (lo_reg == hi_reg);
    assign stat.q_nonzero   = (q_reg != '0);
    assign stat.stack_empty = (sp_reg == '0);
    assign stat.top_phase   = stk_phase[top_idx];
    assign stat.clear_last  = (clr_cnt_reg == NW'(NODES - 1));

    // memory port selection
    always_comb
    begin
        rd_en   = ctrl.rd_node || ctrl.chl_rd || ctrl.chr_rd;
        rd_addr = ctrl.chl_rd ? left_node : (ctrl.chr_rd ? right_node : node_reg);
        sum_we  = 1'b0;
        sum_wa  = node_reg;
        sum_wd  = newsum;
        pend_we = 1'b0;
        pend_wa = node_reg;
        pend_wd = '0;
        if (ctrl.clr_step)
        begin
            sum_we  = 1'b1;
            sum_wa  = clr_cnt_reg;
            sum_wd  = '0;
            pend_we = 1'b1;
            pend_wa = clr_cnt_reg;
        end
        else if (ctrl.wr_node)
        begin
            sum_we  = 1'b1;
            pend_we = 1'b1;
        end
        else if (ctrl.chl_wr || ctrl.chr_wr)
        begin
            pend_we = 1'b1;
            pend_wa = ctrl.chl_wr ? left_node : right_node;
            pend_wd = pend_q + q_reg;
        end
        else if (ctrl.ret_step && stk_phase[top_idx] && (cmd_reg == CMD_ADD))
        begin
            // parent sum rebuilt from the two child sums
            sum_we = 1'b1;
            sum_wa = stk_node[top_idx];
            sum_wd = total;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[sum_wa] <= sum_wd;
        end
        if (pend_we)
        begin
            pend_mem[pend_wa] <= pend_wd;
        end
        if (rd_en)
        begin
            sum_q  <= sum_mem[rd_addr];
            pend_q <= pend_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= CNT_W'(CNT_RESET);
            sp_reg      <= '0;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.emit;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            if (ctrl.load)
            begin
                sp_reg      <= '0;
                clr_cnt_reg <= '0;
            end
            else if (ctrl.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + NW'(1);
            end
            else if (ctrl.descend)
            begin
                sp_reg <= sp_reg + SPW'(1);
            end
            else if (ctrl.ret_step && stk_phase[top_idx])
            begin
                sp_reg <= sp_m1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg  <= command;
            a_reg    <= first_index;
            b_reg    <= last_index;
            v_reg    <= SUM_W'(add_value);
            n_reg    <= n_used;
            node_reg <= '0;
            lo_reg   <= '0;
            hi_reg   <= EW'(n_used - CW'(1));
            ret_reg  <= '0;
        end
        if (ctrl.calc)
        begin
            outside_reg <= outside_c;
            full_reg    <= full_c;
            q_reg       <= q_c;
            prod_reg    <= q_c * SUM_W'(len);
        end
        if (ctrl.wr_node)
        begin
            ret_reg <= ((cmd_reg == CMD_QUERY) && outside_reg) ? '0 : newsum;
        end
        if (ctrl.descend)
        begin
            stk_node[push_idx]  <= node_reg;
            stk_lo[push_idx]    <= lo_reg;
            stk_hi[push_idx]    <= hi_reg;
            stk_phase[push_idx] <= 1'b0;
            node_reg <= left_node;
            hi_reg   <= mid;
        end
        if (ctrl.ret_step)
        begin
            if (!stk_phase[top_idx])
            begin
                stk_acc[top_idx]   <= ret_reg;
                stk_phase[top_idx] <= 1'b1;
                node_reg <= top_right;
                lo_reg   <= top_mid + EW'(1);
                hi_reg   <= stk_hi[top_idx];
            end
            else
            begin
                ret_reg <= total;
            end
        end
        if (ctrl.emit)
        begin
            range_sum_reg <= ret_reg;
        end
    end

    assign done      = done_reg;
    assign range_sum = range_sum_reg;

endmodule

### hw/rtl/range_add_range_sum_tree_unit.sv
// channel  | ports                                          | handshake
// command  | command, first_index, last_index, add_value   | start while busy low
// result   | range_sum                                      | done, one cycle
// config   | cfg_wdata                                      | cfg_we
// each item is first decoded; each visited tree node is then read, updated,
// written back and tested, and when a pending add moves to its children each
// child is read and written too; return steps climb back up the stack, and a
// query adds a result step. the pace is set by the single-port node memories,
// walked one node at a time.
// after reset and on each clear command the node memories are swept, one
// entry a cycle, all 4*MAX_ELEMENTS entries, with busy high.
// results cannot be stalled: done marks range_sum for exactly one cycle.
module range_add_range_sum_tree_unit #(
    parameter int MAX_ELEMENTS = rast_pkg::DEF_MAX_ELEMENTS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [rast_pkg::CMD_W-1:0]        command,
    input  logic [rast_pkg::IDX_W-1:0]        first_index,
    input  logic [rast_pkg::IDX_W-1:0]        last_index,
    input  logic signed [rast_pkg::VAL_W-1:0] add_value,
    output logic                              done,
    output logic signed [rast_pkg::SUM_W-1:0] range_sum,
    input  logic                              cfg_we,
    input  logic [rast_pkg::CNT_W-1:0]        cfg_wdata
);
    import rast_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    rast_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    rast_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .stat        (stat),
        .command     (command),
        .first_index (first_index),
        .last_index  (last_index),
        .add_value   (add_value),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .done        (done),
        .range_sum   (range_sum)
    );

endmodule

### tb/sv/tb_range_add_range_sum_tree_unit.sv
module tb_range_add_range_sum_tree_unit;
    import rast_pkg::*;

    localparam int NODES = 4 * DEF_MAX_ELEMENTS;
    localparam int SETTLE_CYCLES = 600;
    localparam int STALL_LIMIT = 60000;
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    class sum_scoreboard;
        bit [63:0] node_sum [NODES];
        bit [63:0] node_pend [NODES];
        bit [CNT_W-1:0] elem_count;
        longint unsigned sums_due [$];
        int mismatches;
        int checked;

        function new();
            elem_count = CNT_W'(CNT_RESET);
            wipe();
        endfunction

        function void wipe();
            foreach (node_sum[i])
            begin
                node_sum[i] = '0;
                node_pend[i] = '0;
            end
        endfunction

        function bit [63:0] used_len();
            if (elem_count == 0) return 1;
            if (elem_count > DEF_MAX_ELEMENTS) return DEF_MAX_ELEMENTS;
            return elem_count;
        endfunction

        function void push_down(bit [63:0] node, bit [63:0] lo, bit [63:0] hi);
            bit [63:0] p;
            if (node >= NODES) return;
            p = node_pend[node];
            if (p == 0) return;
            node_sum[node] += p * (hi - lo + 1);
            if (lo != hi)
            begin
                if (2 * node + 1 < NODES) node_pend[2 * node + 1] += p;
                if (2 * node + 2 < NODES) node_pend[2 * node + 2] += p;
            end
            node_pend[node] = '0;
        endfunction

        function bit [63:0] tree_sum(bit [63:0] node, bit [63:0] lo, bit [63:0] hi,
                                     bit [63:0] a, bit [63:0] b);
            bit [63:0] mid;
            if (node >= NODES) return 0;
            push_down(node, lo, hi);
            if (a > hi || b < lo) return 0;
            if (a <= lo && b >= hi) return node_sum[node];
            mid = (lo + hi) / 2;
            return tree_sum(2 * node + 1, lo, mid, a, b)
                 + tree_sum(2 * node + 2, mid + 1, hi, a, b);
        endfunction

        function void tree_add(bit [63:0] node, bit [63:0] lo, bit [63:0] hi,
                               bit [63:0] a, bit [63:0] b, bit [63:0] v);
            bit [63:0] mid;
            if (node >= NODES) return;
            push_down(node, lo, hi);
            if (a > hi || b < lo) return;
            if (a <= lo && b >= hi)
            begin
                node_sum[node] += v * (hi - lo + 1);
                if (lo != hi)
                begin
                    if (2 * node + 1 < NODES) node_pend[2 * node + 1] += v;
                    if (2 * node + 2 < NODES) node_pend[2 * node + 2] += v;
                end
                return;
            end
            mid = (lo + hi) / 2;
            tree_add(2 * node + 1, lo, mid, a, b, v);
            tree_add(2 * node + 2, mid + 1, hi, a, b, v);
            if (2 * node + 2 < NODES)
                node_sum[node] = node_sum[2 * node + 1] + node_sum[2 * node + 2];
        endfunction

        function void note_item(bit [CMD_W-1:0] cmd, bit [IDX_W-1:0] a,
                                bit [IDX_W-1:0] b, bit signed [VAL_W-1:0] val);
            bit [63:0] n;
            bit ok;
            n = used_len();
            ok = (a <= b) && (b < n);
            if (cmd == CMD_QUERY)
                sums_due.push_back(ok ? tree_sum(0, 0, n - 1, a, b) : 64'd0);
            else if (cmd == CMD_ADD)
            begin
                if (ok) tree_add(0, 0, n - 1, a, b, 64'(val));
            end
            else if (cmd == CMD_CLEAR)
                wipe();
        endfunction

        function void check_sum(bit [63:0] got);
            bit [63:0] want;
            checked++;
            if (sums_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected range_sum %h", got);
                return;
            end
            want = sums_due.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("range_sum mismatch: expected %h actual %h", want, got);
            end
        endfunction
    endclass

    logic clk, rst_n, start, busy, done, cfg_we;
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] first_index, last_index;
    logic signed [VAL_W-1:0] add_value;
    logic signed [SUM_W-1:0] range_sum;
    logic [CNT_W-1:0] cfg_wdata;

    sum_scoreboard sb;
    int stall_cycles;
    int items_sent;
    int queries_sent;
    bit idle_on;

    range_add_range_sum_tree_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .first_index(first_index), .last_index(last_index),
        .add_value(add_value), .done(done), .range_sum(range_sum),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        sb = new();
        rst_n = 0;
        start = 0;
        command = CMD_QUERY;
        first_index = '0;
        last_index = '0;
        add_value = '0;
        cfg_we = 0;
        cfg_wdata = '0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done) sb.check_sum(range_sum);
        if ((start && !busy) || done || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[range_add_range_sum_tree_unit] ERROR");
            $finish;
        end
    end

    task automatic send_item(bit [CMD_W-1:0] cmd, bit [IDX_W-1:0] a,
                             bit [IDX_W-1:0] b, bit signed [VAL_W-1:0] val);
        int gap;
        if (idle_on && $urandom_range(99) < 37)
        begin
            gap = $urandom_range(1, 6);
            start <= 0;
            repeat (gap) @(posedge clk);
        end
        start <= 1;
        command <= cmd;
        first_index <= a;
        last_index <= b;
        add_value <= val;
        do @(posedge clk); while (busy);
        sb.note_item(cmd, a, b, val);
        items_sent++;
        if (cmd == CMD_QUERY) queries_sent++;
    endtask

    task automatic wait_drained();
        start <= 0;
        @(posedge clk);
        while (busy || sb.sums_due.size() != 0) @(posedge clk);
    endtask

    task automatic write_count(bit [CNT_W-1:0] cnt);
        wait_drained();
        // adds give no result, so let any walk in flight finish
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy) @(posedge clk);
        cfg_we <= 1;
        cfg_wdata <= cnt;
        @(posedge clk);
        cfg_we <= 0;
        sb.elem_count = cnt;
    endtask

    task automatic send_random(int count);
        bit [63:0] n;
        bit [CMD_W-1:0] cmd;
        bit [IDX_W-1:0] a, b, t;
        int r;
        repeat (count)
        begin
            n = sb.used_len();
            r = $urandom_range(999);
            if (r < 470) cmd = CMD_QUERY;
            else if (r < 985) cmd = CMD_ADD;
            else if (r < 989) cmd = CMD_CLEAR;
            else cmd = CMD_SPARE;
            r = $urandom_range(99);
            a = IDX_W'($urandom_range(32'(n - 1)));
            b = IDX_W'($urandom_range(32'(n - 1)));
            if (r < 75)
            begin
                if (a > b)
                begin
                    t = a;
                    a = b;
                    b = t;
                end
            end
            else if (r < 85)
            begin
                if (a < b)
                begin
                    t = a;
                    a = b;
                    b = t;
                end
            end
            else
            begin
                a = IDX_W'($urandom());
                b = IDX_W'($urandom());
            end
            send_item(cmd, a, b, $urandom());
        end
    endtask

    initial
    begin
        bit [CNT_W-1:0] counts [8];
        counts = '{11'd1024, 11'd1, 11'd2, 11'd0, 11'd2047, 11'd37, 11'd1000, 11'd513};
        idle_on = 1;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, reversed and out-of-length ranges, unused code
        write_count(11'd1024);
        send_item(CMD_ADD, 10'd0, 10'd1023, 32'sh7fffffff);
        send_item(CMD_QUERY, 10'd0, 10'd1023, 32'sd0);
        send_item(CMD_ADD, 10'd0, 10'd1023, 32'sh80000000);
        send_item(CMD_QUERY, 10'd0, 10'd1023, 32'sd0);
        send_item(CMD_ADD, 10'd1023, 10'd1023, -32'sd1);
        send_item(CMD_QUERY, 10'd1023, 10'd1023, 32'sd0);
        send_item(CMD_QUERY, 10'd0, 10'd0, 32'sd0);
        send_item(CMD_ADD, 10'd700, 10'd3, 32'sd55);
        send_item(CMD_QUERY, 10'd700, 10'd3, 32'sd0);
        send_item(CMD_SPARE, 10'd0, 10'd1023, 32'sd9);
        send_item(CMD_QUERY, 10'd1, 10'd1022, 32'sd0);
        send_item(CMD_CLEAR, 10'd0, 10'd0, 32'sd0);
        send_item(CMD_QUERY, 10'd0, 10'd1023, 32'sd0);
        write_count(11'd16);
        send_item(CMD_ADD, 10'd0, 10'd15, 32'sd3);
        send_item(CMD_ADD, 10'd5, 10'd16, 32'sd100);
        send_item(CMD_QUERY, 10'd0, 10'd16, 32'sd0);
        send_item(CMD_QUERY, 10'd4, 10'd15, 32'sd0);
        // count changed with data held: tree shape moves under stored sums
        write_count(11'd9);
        send_item(CMD_QUERY, 10'd0, 10'd8, 32'sd0);
        send_item(CMD_ADD, 10'd2, 10'd7, 32'sd11);
        send_item(CMD_QUERY, 10'd1, 10'd5, 32'sd0);

        foreach (counts[i])
        begin
            write_count(counts[i]);
            if (i != 5) send_item(CMD_CLEAR, 10'd0, 10'd0, 32'sd0);
            idle_on = (i != 3);
            send_random(100);
            wait_drained();
            send_random(100);
        end
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d items (%0d queries) over %0d element counts, %0d sums checked",
                 items_sent, queries_sent, 10, sb.checked);
        if (sb.mismatches == 0 && sb.sums_due.size() == 0)
            $display("[range_add_range_sum_tree_unit] OK");
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.mismatches,
                     sb.sums_due.size());
            $display("[range_add_range_sum_tree_unit] ERROR");
        end
        $finish;
    end
endmodule

### sim.f
hw/rtl/rast_pkg.sv
hw/rtl/rast_ctrl.sv
hw/rtl/rast_datapath.sv
hw/rtl/range_add_range_sum_tree_unit.sv
tb/sv/tb_range_add_range_sum_tree_unit.sv
